// ----- src/bmhpq_pkg.sv -----
package bmhpq_pkg;

  localparam int unsigned Capacity  = 64;
  localparam int unsigned IdBits    = 16;
  localparam int unsigned PriBits   = 8;
  localparam int unsigned CountBits = 7;

  typedef enum logic {
    ActInsert  = 1'b0,
    ActExtract = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    StInserted  = 2'd0,
    StExtracted = 2'd1,
    StFull      = 2'd2,
    StEmpty     = 2'd3
  } status_e;

  typedef struct packed {
    logic [IdBits-1:0]  id;
    logic [PriBits-1:0] pri;
  } entry_t;

  typedef struct packed {
    action_e            action;
    logic [IdBits-1:0]  entry_id;
    logic [PriBits-1:0] entry_priority;
  } in_beat_t;

  typedef struct packed {
    status_e              status;
    logic [IdBits-1:0]    out_id;
    logic [PriBits-1:0]   out_priority;
    logic [CountBits-1:0] count;
  } out_beat_t;

endpackage

// ----- src/bmhpq_ram.sv -----
module bmhpq_ram
  import bmhpq_pkg::*;
#(
  parameter int unsigned DEPTH = Capacity
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  entry_t                     wdata_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_b_i,
  output entry_t                     rdata_a_o,
  output entry_t                     rdata_b_o
);

  entry_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, two ports.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- src/binary_max_heap_priority_queue_core.sv -----
// Channel | Direction | Handshake                | Beat type
// in      | input     | in_valid_i / in_ready_o   | in_beat_t  (action, entry_id, entry_priority)
// out     | output    | out_valid_o / out_ready_i | out_beat_t (status, out_id, out_priority, count)
//
// One item at a time: in_ready_o is high only in the idle state.
// Insert climbs a level per SUpRd/SUpCmp pass; extract loads root and last entry (SExLoad),
//   then descends a level per SDnRd/SDnCmp pass. Each pass is the read/compare/
//   write loop around the two-read, one-write heap memory.
// Full insert and empty extract go straight to SEmit.
// Reset clears the entry count and control state; the heap memory is not cleared.
// A stalled output holds its beat; the next item is accepted while a beat waits.
module binary_max_heap_priority_queue_core
  import bmhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = Capacity
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  localparam int unsigned AW = $clog2(CAPACITY);      // heap slot address
  localparam int unsigned CW = $clog2(CAPACITY + 1);  // entry count
  localparam int unsigned LW = AW + 2;                // child index, may run past the end

  typedef enum logic [2:0] {
    SIdle,
    SUpRd,
    SUpCmp,
    SExLoad,
    SDnRd,
    SDnCmp,
    SEmit
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        hole_q, hole_d;
  entry_t               cur_q, cur_d;        // entry being sifted
  entry_t               res_q, res_d;        // extracted entry
  status_e              status_q, status_d;
  logic                 out_valid_q, out_valid_d;
  out_beat_t            out_q, out_d;

  logic                 we;
  logic [AW-1:0]        waddr;
  entry_t               wdata;
  logic [AW-1:0]        raddr_a, raddr_b;
  entry_t               rd_a, rd_b;

  logic [AW-1:0]        parent;
  logic [LW-1:0]        lc_w, rc_w, count_w;
  logic                 rc_ok, take_l, take_r;
  logic [PriBits-1:0]   best_pri;

  bmhpq_ram #(
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  // Heap index arithmetic around the hole.
  assign parent  = (hole_q - AW'(1)) >> 1;
  assign lc_w    = LW'({hole_q, 1'b1});
  assign rc_w    = lc_w + LW'(1);
  assign count_w = LW'(count_q);
  assign rc_ok   = rc_w < count_w;

  // Sift-down compare: left child first, right only if strictly above the best so far.
  assign take_l   = rd_a.pri > cur_q.pri;
  assign best_pri = take_l ? rd_a.pri : cur_q.pri;
  assign take_r   = rc_ok && (rd_b.pri > best_pri);

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    hole_d      = hole_q;
    cur_d       = cur_q;
    res_d       = res_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    we          = 1'b0;
    waddr       = hole_q;
    wdata       = cur_q;
    raddr_a     = '0;
    raddr_b     = '0;

    // Drop the beat once taken.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          res_d = '0;
          if (in_data_i.action == ActInsert) begin
            if (count_q == CW'(CAPACITY)) begin
              status_d = StFull;
              state_d  = SEmit;
            end else begin
              // Place at the end, then climb.
              cur_d    = '{id: in_data_i.entry_id, pri: in_data_i.entry_priority};
              hole_d   = AW'(count_q);
              count_d  = count_q + CW'(1);
              status_d = StInserted;
              state_d  = SUpRd;
            end
          end else begin
            if (count_q == '0) begin
              status_d = StEmpty;
              state_d  = SEmit;
            end else begin
              // Fetch root and last entry together.
              raddr_a = '0;
              raddr_b = AW'(count_q - CW'(1));
              state_d = SExLoad;
            end
          end
        end
      end

      SUpRd: begin
        if (hole_q == '0) begin
          we      = 1'b1;
          state_d = SEmit;
        end else begin
          raddr_a = parent;
          state_d = SUpCmp;
        end
      end

      SUpCmp: begin
        we = 1'b1;
        if (rd_a.pri < cur_q.pri) begin
          // Move the parent down into the hole and advance upward.
          wdata   = rd_a;
          hole_d  = parent;
          state_d = SUpRd;
        end else begin
          state_d = SEmit;
        end
      end

      SExLoad: begin
        res_d    = rd_a;
        cur_d    = rd_b;
        count_d  = count_q - CW'(1);
        hole_d   = '0;
        status_d = StExtracted;
        state_d  = (count_q == CW'(1)) ? SEmit : SDnRd;
      end

      SDnRd: begin
        if (lc_w >= count_w) begin
          // No children: settle here.
          we      = 1'b1;
          state_d = SEmit;
        end else begin
          raddr_a = lc_w[AW-1:0];
          raddr_b = rc_w[AW-1:0];
          state_d = SDnCmp;
        end
      end

      SDnCmp: begin
        we = 1'b1;
        if (take_r) begin
          wdata   = rd_b;
          hole_d  = rc_w[AW-1:0];
          state_d = SDnRd;
        end else if (take_l) begin
          wdata   = rd_a;
          hole_d  = lc_w[AW-1:0];
          state_d = SDnRd;
        end else begin
          state_d = SEmit;
        end
      end

      SEmit: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_d.status       = status_q;
          out_d.out_id       = res_q.id;
          out_d.out_priority = res_q.pri;
          out_d.count        = CountBits'(count_q);
          state_d            = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      hole_q      <= '0;
      cur_q       <= '0;
      res_q       <= '0;
      status_q    <= StInserted;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      hole_q      <= hole_d;
      cur_q       <= cur_d;
      res_q       <= res_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

endmodule

// ----- src/bmhpq_chk.sv -----
module bmhpq_chk
  import bmhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = Capacity
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_beat_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_beat_t out_data_o
);

  // A stalled beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // Only an extract carries an entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != StExtracted) |->
      (out_data_o.out_id == '0) && (out_data_o.out_priority == '0))
    else $error("non-extract beat carries entry data");

  // Empty report only with nothing held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == StEmpty) |-> out_data_o.count == '0)
    else $error("empty status with nonzero count");

  // Full refusal only at capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == StFull) |->
      out_data_o.count == CountBits'(CAPACITY))
    else $error("full status below capacity");

  // A successful insert leaves at least one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == StInserted) |-> out_data_o.count != '0)
    else $error("insert beat reports empty queue");

endmodule

bind binary_max_heap_priority_queue_core bmhpq_chk #(.CAPACITY(CAPACITY)) u_bmhpq_chk (.*);
